### design/heater_pid_with_bang_band_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the heater controller
// Shorthand for clocked properties on clk with reset arst_n.
// ----------------------------------------------------------------------------
`ifndef HEATER_PID_WITH_BANG_BAND_ASSERT_SVH
`define HEATER_PID_WITH_BANG_BAND_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define HPB_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HPB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/hpb_pkg.sv
// ----------------------------------------------------------------------------
// Heater controller package
// Widths, codes, reset values and shared types of the heater PID block.
// ----------------------------------------------------------------------------
package hpb_pkg;

	localparam int MeasW     = 13;  // measured temperature, 1/16 degree
	localparam int TgtW      = 9;   // target temperature, whole degrees
	localparam int ErrW      = 14;  // signed error and measurement step
	localparam int GainW     = 24;  // Q12.12 gains
	localparam int ByteW     = 8;   // byte-wide registers and drive
	localparam int FracW     = 8;   // smoothing weight in 1/256
	localparam int DriveFrac = 16;  // drive sums are Q.16
	localparam int SumW      = 32;  // integrator and filtered derivative
	localparam int AccW      = 58;  // serial accumulator
	localparam int MultW     = 24;  // serial multiplier operand
	localparam int CntW      = 5;   // serial bit counter
	localparam int CfgIdxW   = 3;
	localparam int InDataW   = 24;
	localparam int OutDataW  = 8;
	localparam int RegionW   = 3;

	localparam logic [ByteW-1:0] SmoothRst = 8'd243;
	localparam logic [ByteW-1:0] BandRst   = 8'd10;
	localparam logic [ByteW-1:0] BangRst   = 8'd255;
	localparam logic [ByteW-1:0] CeilRst   = 8'd255;

	localparam logic [CfgIdxW-1:0] CFG_GAIN_PROP  = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_GAIN_INTEG = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_GAIN_DERIV = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_SMOOTH     = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_BAND       = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_BANG       = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_CEILING    = 3'd6;

	typedef enum logic [RegionW-1:0] {
		REGION_BANG     = 3'd0,
		REGION_OFF      = 3'd1,
		REGION_PID      = 3'd2,
		REGION_CLAMP_HI = 3'd3,
		REGION_CLAMP_LO = 3'd4
	} region_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KD,
		ST_WS,
		ST_SF,
		ST_FILT,
		ST_KP,
		ST_KI,
		ST_FD,
		ST_CLAMP,
		ST_OUT
	} seq_state_t;

	// One command to the serial multiply-accumulate unit.
	typedef struct packed {
		logic            start;
		logic            clear;
		logic            msb_neg;
		logic [CntW-1:0] nbits;
	} mac_cmd_t;

endpackage

### design/hpb_serial_mac.sv
// ----------------------------------------------------------------------------
// Bit-serial multiply-accumulate
// Adds mcand * mult into the accumulator, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module hpb_serial_mac import hpb_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mac_cmd_t               cmd,
	input  logic signed [AccW-1:0] mcand,
	input  logic [MultW-1:0]       mult,
	output logic signed [AccW-1:0] acc,
	output logic                   busy
);

	logic signed [AccW-1:0] mcand_q;
	logic signed [AccW-1:0] acc_q;
	logic [MultW-1:0]       mult_q;
	logic [CntW-1:0]        cnt_q;
	logic                   neg_q;
	logic                   run_q;

	logic                   last;
	logic                   sub;
	logic [AccW-1:0]        addend;
	logic [AccW-1:0]        sum;

	// The top multiplier bit carries negative weight for signed multipliers.
	always_comb begin
		last   = (cnt_q == CntW'(1));
		sub    = last & neg_q;
		addend = mult_q[0] ? (sub ? ~mcand_q : mcand_q) : '0;
		sum    = acc_q + addend + AccW'(mult_q[0] & sub);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (cmd.start) begin
			run_q <= 1'b1;
			cnt_q <= cmd.nbits;
		end else if (run_q) begin
			cnt_q <= cnt_q - CntW'(1);
			if (last) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mcand_q <= mcand;
			mult_q  <= mult;
			neg_q   <= cmd.msb_neg;
			if (cmd.clear) begin
				acc_q <= '0;
			end
		end else if (run_q) begin
			acc_q   <= sum;
			mcand_q <= mcand_q <<< 1;
			mult_q  <= mult_q >> 1;
		end
	end

	assign acc  = acc_q;
	assign busy = run_q;

endmodule

### design/heater_pid_with_bang_band.sv
// ----------------------------------------------------------------------------
// Heater PID controller with bang-bang band
// Each input item carries a measured temperature (1/16 degree, tdata bits
// 12:0) and a target (whole degrees, bits 21:13, zero turns the heater off);
// each produces exactly one result item: a drive level on tdata and a region
// code on tuser (bang full, off, regulating, clamped high, clamped low). The
// derivative-on-measurement term is low-pass filtered on every item. Far
// below target the drive is the bang level, far above or with a zero target
// it is off, and both mark the integrator for clearing; inside the band a
// PID sum is clamped to 0..drive_ceiling with conditional un-integration.
// All products go through one bit-serial multiply-accumulate unit, one
// multiplier bit per cycle; the multiplier bit count of each step is 14
// for the measurement step, 9 and 8 for the filter weights, 14 for the
// error, 24 for the integral gain and 1 for the filtered derivative, and
// an item outside the band skips the last three steps. One item is in
// work at a time; a finished result sits in the output register while the
// next item is accepted. Configuration writes are always taken (cfg_ready
// is tied high) and must only be issued while idle.
// ----------------------------------------------------------------------------
module heater_pid_with_bang_band import hpb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CfgIdxW-1:0]   cfg_index,
	input  logic [GainW-1:0]     cfg_data,
	// input items
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [InDataW-1:0]   s_axis_tdata,   // [12:0] measured_temp, [21:13] target_temp
	// result items
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [OutDataW-1:0]  m_axis_tdata,   // [7:0] drive
	output logic [RegionW-1:0]   m_axis_tuser    // [2:0] region
);

	localparam int WideW = AccW - FracW;

	// Saturate a 33-bit integrator sum to 32 bits.
	function automatic logic [SumW-1:0] sat_sum(input logic [SumW:0] v);
		if (v[SumW] == v[SumW-1]) begin
			return v[SumW-1:0];
		end else if (v[SumW]) begin
			return {1'b1, {(SumW-1){1'b0}}};
		end else begin
			return {1'b0, {(SumW-1){1'b1}}};
		end
	endfunction

	// Saturate the shifted filter accumulator to 32 bits.
	function automatic logic [SumW-1:0] sat_wide(input logic [WideW-1:0] v);
		logic [WideW-SumW:0] hi;
		hi = v[WideW-1:SumW-1];
		if ((&hi) || !(|hi)) begin
			return v[SumW-1:0];
		end else if (v[WideW-1]) begin
			return {1'b1, {(SumW-1){1'b0}}};
		end else begin
			return {1'b0, {(SumW-1){1'b1}}};
		end
	endfunction

	// configuration registers
	logic [GainW-1:0]  kp_q, ki_q, kd_q;
	logic [ByteW-1:0]  smooth_q, band_q, bang_q, ceil_q;

	// controller state
	logic [SumW-1:0]   es_q;
	logic [MeasW-1:0]  prev_q;
	logic [SumW-1:0]   fd_q;
	logic              pend_q;

	// per-item working registers
	logic [MeasW-1:0]  meas_q;
	logic [ErrW-1:0]   err_q;
	logic              tgt_zero_q;
	logic [ByteW-1:0]  res_drive_q;
	region_t           res_region_q;

	// result register
	logic              out_valid_q;
	logic [ByteW-1:0]  out_drive_q;
	region_t           out_region_q;

	seq_state_t        state_q, state_d;

	// serial unit
	mac_cmd_t               mac_cmd;
	logic signed [AccW-1:0] mac_mcand;
	logic [MultW-1:0]       mac_mult;
	logic signed [AccW-1:0] mac_acc;
	logic                   mac_busy;

	// datapath
	logic              in_accept;
	logic [MeasW-1:0]  in_meas;
	logic [TgtW-1:0]   in_tgt;
	logic [ErrW-1:0]   in_diff;
	logic [ErrW-1:0]   in_err;
	logic [FracW:0]    weight;
	logic [AccW-1:0]   round_acc;
	logic [SumW-1:0]   fd_next;
	logic [ErrW+1:0]   err_w, band_w, err_plus_band;
	logic              is_bang, is_off;
	logic [SumW:0]     err_ext, es_base;
	logic [SumW-1:0]   es_add, es_sub;
	logic [AccW-1:0]   top_w;
	logic              u_high, u_low;
	logic              out_load;

	assign cfg_ready = 1'b1;

	hpb_serial_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.mcand  (mac_mcand),
		.mult   (mac_mult),
		.acc    (mac_acc),
		.busy   (mac_busy)
	);

	// ---- input decode and per-item arithmetic ----
	always_comb begin
		in_accept = s_axis_tvalid && s_axis_tready;
		in_meas   = s_axis_tdata[MeasW-1:0];
		in_tgt    = s_axis_tdata[MeasW+TgtW-1:MeasW];
		in_diff   = {1'b0, in_meas} - {1'b0, prev_q};
		in_err    = {1'b0, in_tgt, 4'b0000} - {1'b0, in_meas};
		weight    = {1'b1, {FracW{1'b0}}} - {1'b0, smooth_q};

		// filter: floor((acc + 128) / 256), then saturate
		round_acc = mac_acc + AccW'(1 << (FracW-1));
		fd_next   = sat_wide(round_acc[AccW-1:FracW]);

		// band test on the error
		err_w         = {{2{err_q[ErrW-1]}}, err_q};
		band_w        = {4'b0000, band_q, 4'b0000};
		err_plus_band = err_w + band_w;
		is_bang       = $signed(err_w) > $signed(band_w);
		is_off        = err_plus_band[ErrW+1] || tgt_zero_q;

		// integrator add and un-integration, saturating
		err_ext = {{(SumW+1-ErrW){err_q[ErrW-1]}}, err_q};
		es_base = pend_q ? '0 : {es_q[SumW-1], es_q};
		es_add  = sat_sum(es_base + err_ext);
		es_sub  = sat_sum({es_q[SumW-1], es_q} - err_ext);

		// clamp against 0 and ceiling in Q.16
		top_w  = {{(AccW-ByteW-DriveFrac){1'b0}}, ceil_q, {DriveFrac{1'b0}}};
		u_high = mac_acc > $signed(top_w);
		u_low  = mac_acc[AccW-1];

		out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);
	end

	// ---- sequencer: next state ----
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_accept) state_d = ST_KD;
			ST_KD:    if (!mac_busy) state_d = ST_WS;
			ST_WS:    if (!mac_busy) state_d = ST_SF;
			ST_SF:    if (!mac_busy) state_d = ST_FILT;
			ST_FILT:  state_d = (is_bang || is_off) ? ST_OUT : ST_KP;
			ST_KP:    if (!mac_busy) state_d = ST_KI;
			ST_KI:    if (!mac_busy) state_d = ST_FD;
			ST_FD:    if (!mac_busy) state_d = ST_CLAMP;
			ST_CLAMP: state_d = ST_OUT;
			ST_OUT:   if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// ---- sequencer: outputs (serial unit commands) ----
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		mac_cmd       = '0;
		mac_mcand     = '0;
		mac_mult      = '0;
		case (state_q)
			ST_IDLE: begin
				// Kd * step of the measurement
				if (in_accept) begin
					mac_cmd   = '{start: 1'b1, clear: 1'b1, msb_neg: 1'b1, nbits: CntW'(ErrW)};
					mac_mcand = {{(AccW-GainW){1'b0}}, kd_q};
					mac_mult  = {{(MultW-ErrW){in_diff[ErrW-1]}}, in_diff};
				end
			end
			ST_KD: begin
				// (256 - s) * (Kd * d)
				if (!mac_busy) begin
					mac_cmd   = '{start: 1'b1, clear: 1'b1, msb_neg: 1'b0, nbits: CntW'(FracW+1)};
					mac_mcand = mac_acc;
					mac_mult  = {{(MultW-FracW-1){1'b0}}, weight};
				end
			end
			ST_WS: begin
				// + s * old filtered derivative
				if (!mac_busy) begin
					mac_cmd   = '{start: 1'b1, clear: 1'b0, msb_neg: 1'b0, nbits: CntW'(FracW)};
					mac_mcand = {{(AccW-SumW){fd_q[SumW-1]}}, fd_q};
					mac_mult  = {{(MultW-FracW){1'b0}}, smooth_q};
				end
			end
			ST_FILT: begin
				// Kp * error, only when regulating
				if (!(is_bang || is_off)) begin
					mac_cmd   = '{start: 1'b1, clear: 1'b1, msb_neg: 1'b1, nbits: CntW'(ErrW)};
					mac_mcand = {{(AccW-GainW){1'b0}}, kp_q};
					mac_mult  = {{(MultW-ErrW){err_q[ErrW-1]}}, err_q};
				end
			end
			ST_KP: begin
				// + Ki * integrator
				if (!mac_busy) begin
					mac_cmd   = '{start: 1'b1, clear: 1'b0, msb_neg: 1'b0, nbits: CntW'(GainW)};
					mac_mcand = {{(AccW-SumW){es_q[SumW-1]}}, es_q};
					mac_mult  = ki_q;
				end
			end
			ST_KI: begin
				// - filtered derivative: a one-bit signed multiply by -1
				if (!mac_busy) begin
					mac_cmd   = '{start: 1'b1, clear: 1'b0, msb_neg: 1'b1, nbits: CntW'(1)};
					mac_mcand = {{(AccW-SumW){fd_q[SumW-1]}}, fd_q};
					mac_mult  = MultW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			kp_q        <= '0;
			ki_q        <= '0;
			kd_q        <= '0;
			smooth_q    <= SmoothRst;
			band_q      <= BandRst;
			bang_q      <= BangRst;
			ceil_q      <= CeilRst;
			es_q        <= '0;
			prev_q      <= '0;
			fd_q        <= '0;
			pend_q      <= 1'b0;
		end else begin
			state_q <= state_d;

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_GAIN_PROP:  kp_q     <= cfg_data;
					CFG_GAIN_INTEG: ki_q     <= cfg_data;
					CFG_GAIN_DERIV: kd_q     <= cfg_data;
					CFG_SMOOTH:     smooth_q <= cfg_data[ByteW-1:0];
					CFG_BAND:       band_q   <= cfg_data[ByteW-1:0];
					CFG_BANG:       bang_q   <= cfg_data[ByteW-1:0];
					CFG_CEILING:    ceil_q   <= cfg_data[ByteW-1:0];
					default: begin
					end
				endcase
			end

			if (state_q == ST_FILT) begin
				fd_q   <= fd_next;
				prev_q <= meas_q;
				if (is_bang || is_off) begin
					pend_q <= 1'b1;
				end else begin
					// drop a pending clear and integrate
					pend_q <= 1'b0;
					es_q   <= es_add;
				end
			end

			// back off the integrator when the clamp works against the error
			if (state_q == ST_CLAMP) begin
				if ((u_high && !err_q[ErrW-1] && (err_q != '0)) ||
				    (!u_high && u_low && err_q[ErrW-1])) begin
					es_q <= es_sub;
				end
			end
		end
	end

	// ---- payload registers ----
	always_ff @(posedge clk) begin
		if (in_accept) begin
			meas_q     <= in_meas;
			err_q      <= in_err;
			tgt_zero_q <= (in_tgt == '0);
		end

		if (state_q == ST_FILT) begin
			if (is_bang) begin
				res_drive_q  <= bang_q;
				res_region_q <= REGION_BANG;
			end else if (is_off) begin
				res_drive_q  <= '0;
				res_region_q <= REGION_OFF;
			end
		end

		if (state_q == ST_CLAMP) begin
			if (u_high) begin
				res_drive_q  <= ceil_q;
				res_region_q <= REGION_CLAMP_HI;
			end else if (u_low) begin
				res_drive_q  <= '0;
				res_region_q <= REGION_CLAMP_LO;
			end else begin
				res_drive_q  <= mac_acc[DriveFrac+ByteW-1:DriveFrac];
				res_region_q <= REGION_PID;
			end
		end

		if (out_load) begin
			out_drive_q  <= res_drive_q;
			out_region_q <= res_region_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_drive_q;
	assign m_axis_tuser  = out_region_q;

endmodule

### design/hpb_checker.sv
// ----------------------------------------------------------------------------
// Heater controller port checker
// Watches the stream ports of the heater controller over time.
// ----------------------------------------------------------------------------
`include "heater_pid_with_bang_band_assert.svh"

module hpb_checker import hpb_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_axis_tvalid,
	input logic                s_axis_tready,
	input logic                m_axis_tvalid,
	input logic                m_axis_tready,
	input logic [OutDataW-1:0] m_axis_tdata,
	input logic [RegionW-1:0]  m_axis_tuser
);

	// Off and clamped-low results never drive the heater.
	`HPB_ASSERT_SAME(a_zero_drive, m_axis_tvalid && (m_axis_tuser == REGION_OFF || m_axis_tuser == REGION_CLAMP_LO), m_axis_tdata == '0, "nonzero drive in an off or clamped-low result")

	// One item at a time: an accepted item blocks the input.
	`HPB_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after an accepted item")

	// A new result appears only at the end of an item's work.
	`HPB_ASSERT_SAME(a_result_from_work, $rose(m_axis_tvalid), $past(!s_axis_tready), "result appeared while the block was idle")

	// A stalled result holds.
	`HPB_ASSERT_NEXT(a_hold_stalled, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind heater_pid_with_bang_band hpb_checker u_hpb_checker (.*);
